// ----- hw/rtl/pcxd_pkg.sv -----
// Shared constants and controller/datapath interface types for the PCX
// run-length line decoder. No dependencies.
package pcxd_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PIXEL_WIDTH   = 16;
  localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);
  localparam int BYTE_W        = 8;
  localparam int COUNT_W       = 6;
  localparam int LINE_W        = 16;
  localparam int PAL_WORD_W    = 16;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [BYTE_W-1:0]  RUN_CODE_MIN   = 8'hc0;
  localparam logic [BYTE_W-1:0]  RUN_COUNT_MASK = 8'h3f;

  localparam logic [LINE_W-1:0]  LINE_LENGTH_RESET = 16'd320;

  // input op codes
  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_DATA      = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_MODE = 1'b1;

  typedef struct packed {
    logic take_item;  // input beat accepted this cycle
    logic emit;       // load one pixel into the output register
  } pcxd_cmd_t;

  typedef struct packed {
    logic starts_emit;  // the item on the input causes at least one pixel
    logic out_free;     // output register can take a pixel this cycle
    logic final_pixel;  // pixel being emitted is the last of this item
  } pcxd_sts_t;

endpackage

// ----- hw/rtl/pcxd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pcxd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/pcxd_ctrl.sv -----
// Controller for the PCX line decoder: accepts input beats in IDLE and
// steps the pixel emission loop in EMIT. Depends on pcxd_pkg.
module pcxd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcxd_pkg::pcxd_sts_t sts,
  output pcxd_pkg::pcxd_cmd_t cmd
);

  typedef enum logic {
    IDLE,
    EMIT
  } state_t;

  state_t state;

  always_comb begin
    in_ready      = (state == IDLE);
    cmd.take_item = in_valid && (state == IDLE);
    cmd.emit      = (state == EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.take_item && sts.starts_emit) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (cmd.emit && sts.final_pixel) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/pcxd_dp.sv -----
// Datapath for the PCX line decoder: configuration, run decode state,
// line counter, palette memory and output register. Depends on pcxd_pkg
// and pcxd_ram.
module pcxd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pcxd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pcxd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 op,
  input  logic [pcxd_pkg::PAL_ADDR_W-1:0]      palette_index,
  input  logic [pcxd_pkg::PAL_WORD_W-1:0]      palette_value,
  input  logic [pcxd_pkg::BYTE_W-1:0]          data_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pcxd_pkg::PIXEL_WIDTH-1:0]     pixel,
  output logic                                 last_of_run,
  output logic                                 line_end,
  input  pcxd_pkg::pcxd_cmd_t                  cmd,
  output pcxd_pkg::pcxd_sts_t                  sts
);

  logic [pcxd_pkg::LINE_W-1:0]     line_length;
  logic                            palette_mode;
  logic                            awaiting_value;
  logic [pcxd_pkg::COUNT_W-1:0]    run_count;
  logic [pcxd_pkg::LINE_W-1:0]     pixels_left;
  logic [pcxd_pkg::COUNT_W-1:0]    count;
  logic [pcxd_pkg::BYTE_W-1:0]     value_byte;

  logic                            cfg_write;
  logic                            is_code;
  logic                            line_last;
  logic [pcxd_pkg::LINE_W-1:0]     line_load;
  logic [pcxd_pkg::LINE_W-1:0]     cfg_line_load;
  logic [pcxd_pkg::PAL_WORD_W-1:0] pal_rdata;
  logic [pcxd_pkg::PIXEL_WIDTH-1:0] pixel_next;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // a zero line length counts as one
  assign line_load     = (line_length == '0) ? pcxd_pkg::LINE_W'(1) : line_length;
  assign cfg_line_load = (cfg_data[pcxd_pkg::LINE_W-1:0] == '0) ?
                         pcxd_pkg::LINE_W'(1) : cfg_data[pcxd_pkg::LINE_W-1:0];

  assign is_code   = (data_byte >= pcxd_pkg::RUN_CODE_MIN);
  assign line_last = (pixels_left == pcxd_pkg::LINE_W'(1));

  always_comb begin
    sts.starts_emit = (op == pcxd_pkg::OP_DATA) &&
                      (awaiting_value ? (run_count != '0) : !is_code);
    sts.out_free    = !out_valid || out_ready;
    sts.final_pixel = (count == pcxd_pkg::COUNT_W'(1)) || line_last;
  end

  pcxd_ram #(
    .WIDTH (pcxd_pkg::PAL_WORD_W),
    .DEPTH (pcxd_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (cmd.take_item && (op == pcxd_pkg::OP_PAL_WRITE)),
    .waddr (palette_index),
    .wdata (palette_value),
    .re    (cmd.take_item && (op == pcxd_pkg::OP_DATA)),
    .raddr (data_byte),
    .rdata (pal_rdata)
  );

  always_comb begin
    if (palette_mode) begin
      pixel_next = pal_rdata[pcxd_pkg::PIXEL_WIDTH-1:0];
    end else begin
      pixel_next = pcxd_pkg::PIXEL_WIDTH'(value_byte);
    end
  end

  // configuration and run decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= pcxd_pkg::LINE_LENGTH_RESET;
      palette_mode   <= 1'b0;
      awaiting_value <= 1'b0;
      run_count      <= '0;
      pixels_left    <= pcxd_pkg::LINE_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pcxd_pkg::REG_LINE_LENGTH: begin
          // restart the line and drop a pending run code
          line_length    <= cfg_data[pcxd_pkg::LINE_W-1:0];
          pixels_left    <= cfg_line_load;
          awaiting_value <= 1'b0;
          run_count      <= '0;
        end
        pcxd_pkg::REG_PALETTE_MODE: begin
          palette_mode <= cfg_data[0];
        end
        default: ;
      endcase
    end else begin
      if (cmd.take_item && (op == pcxd_pkg::OP_DATA)) begin
        if (awaiting_value) begin
          awaiting_value <= 1'b0;
          run_count      <= '0;
        end else if (is_code) begin
          awaiting_value <= 1'b1;
          run_count      <= pcxd_pkg::COUNT_W'(data_byte & pcxd_pkg::RUN_COUNT_MASK);
        end
      end
      if (cmd.emit) begin
        pixels_left <= line_last ? line_load : pixels_left - pcxd_pkg::LINE_W'(1);
      end
    end
  end

  // emission counter and value byte
  always_ff @(posedge clk) begin
    if (cmd.take_item && (op == pcxd_pkg::OP_DATA)) begin
      value_byte <= data_byte;
      count      <= awaiting_value ? run_count : pcxd_pkg::COUNT_W'(1);
    end else if (cmd.emit) begin
      count <= count - pcxd_pkg::COUNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel       <= pixel_next;
      last_of_run <= sts.final_pixel;
      line_end    <= line_last;
    end
  end

endmodule

// ----- hw/rtl/pcx_rle_line_decoder_top.sv -----
// PCX run-length scanline decoder, top level: controller, datapath and
// palette RAM. Depends on pcxd_pkg, pcxd_ctrl, pcxd_dp and pcxd_ram.
//
// Feed compressed bytes (op = 1) or palette writes (op = 0) on the input
// channel. A palette write, a run code byte and a run value with a zero
// count give no pixel and leave the decoder idle. A literal is accepted,
// and its palette entry read, in IDLE; its pixel is emitted in EMIT.
// A run value byte with count n gives m = min(n, pixels left in the line)
// pixels: the emission loop puts out one pixel per cycle into the output
// register while the output is free, and input is held off until the loop
// finishes. A stalled output holds the loop. The palette RAM is not
// cleared: read only entries that have been written. Configuration is
// always ready; write it only while the decoder is idle.
module pcx_rle_line_decoder_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcxd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcxd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [pcxd_pkg::PAL_ADDR_W-1:0]  palette_index,
  input  logic [pcxd_pkg::PAL_WORD_W-1:0]  palette_value,
  input  logic [pcxd_pkg::BYTE_W-1:0]      data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pcxd_pkg::PIXEL_WIDTH-1:0] pixel,
  output logic                             last_of_run,
  output logic                             line_end
);

  pcxd_pkg::pcxd_cmd_t cmd;
  pcxd_pkg::pcxd_sts_t sts;

  pcxd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcxd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .palette_index (palette_index),
    .palette_value (palette_value),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel         (pixel),
    .last_of_run   (last_of_run),
    .line_end      (line_end),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ----- bench/tb_pcx_rle_line_decoder_top.sv -----
// Testbench for pcx_rle_line_decoder_top: sends palette writes and compressed
// bytes, predicts every decoded pixel beat and checks the output stream in order.
// Depends on pcxd_pkg and the decoder RTL; reads no files.
module tb_pcx_rle_line_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int QUIET_CYCLES = 8;

  typedef struct packed {
    logic [pcxd_pkg::PIXEL_WIDTH-1:0] word;
    logic                             last_of_run;
    logic                             line_end;
  } pixel_beat_t;

  // Tracks decoder state and palette, and holds the pixel beats still owed.
  class pcx_pixel_predictor;
    logic [pcxd_pkg::LINE_W-1:0]     line_length;
    bit                              palette_mode;
    bit                              awaiting_value;
    logic [pcxd_pkg::COUNT_W-1:0]    run_count;
    int unsigned                     pixels_left;
    logic [pcxd_pkg::PAL_WORD_W-1:0] palette [pcxd_pkg::PALETTE_DEPTH];
    bit                              written [pcxd_pkg::PALETTE_DEPTH];
    pixel_beat_t                     expected_pixels [$];
    int                              mismatches;

    function new();
      line_length    = pcxd_pkg::LINE_LENGTH_RESET;
      palette_mode   = 1'b0;
      awaiting_value = 1'b0;
      run_count      = '0;
      mismatches     = 0;
      pixels_left    = line_load();
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // A zero line length behaves as one pixel per line.
    function int unsigned line_load();
      return (line_length == '0) ? 1 : int'(line_length);
    endfunction

    function void write_reg(logic [pcxd_pkg::CFG_INDEX_W-1:0] idx,
                            logic [pcxd_pkg::CFG_DATA_W-1:0] data);
      if (idx == pcxd_pkg::REG_LINE_LENGTH) begin
        line_length    = data;
        pixels_left    = line_load();
        awaiting_value = 1'b0;
        run_count      = '0;
      end else if (idx == pcxd_pkg::REG_PALETTE_MODE) begin
        palette_mode = data[0];
      end
    endfunction

    // Queue up to count copies of word; drop whatever runs past the line end.
    function void queue_pixels(logic [pcxd_pkg::PIXEL_WIDTH-1:0] word, int unsigned count);
      int unsigned n;
      int unsigned k;
      pixel_beat_t beat;
      n = (count < pixels_left) ? count : pixels_left;
      for (k = 0; k < n; k++) begin
        pixels_left--;
        beat.word        = word;
        beat.last_of_run = (k + 1 == n);
        beat.line_end    = (pixels_left == 0);
        expected_pixels.push_back(beat);
        if (pixels_left == 0) pixels_left = line_load();
      end
    endfunction

    function void take_byte(logic o, logic [pcxd_pkg::PAL_ADDR_W-1:0] idx,
                            logic [pcxd_pkg::PAL_WORD_W-1:0] val,
                            logic [pcxd_pkg::BYTE_W-1:0] b);
      logic [pcxd_pkg::PIXEL_WIDTH-1:0] word;
      int unsigned count;
      if (o == pcxd_pkg::OP_PAL_WRITE) begin
        palette[idx] = val;
        written[idx] = 1'b1;
        return;
      end
      word = palette_mode ? palette[b] : pcxd_pkg::PIXEL_WIDTH'(b);
      if (awaiting_value) begin
        // a value byte is never a new code, even at 0xC0 and above
        count          = 32'(run_count);
        awaiting_value = 1'b0;
        run_count      = '0;
        queue_pixels(word, count);
      end else if (b >= pcxd_pkg::RUN_CODE_MIN) begin
        run_count      = pcxd_pkg::COUNT_W'(b & pcxd_pkg::RUN_COUNT_MASK);
        awaiting_value = 1'b1;
      end else begin
        queue_pixels(word, 32'd1);
      end
    endfunction

    function void check_pixel(logic [pcxd_pkg::PIXEL_WIDTH-1:0] got_word, logic got_last,
                              logic got_end);
      pixel_beat_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pixel beat: pixel %h last_of_run %b line_end %b",
                   $realtime, got_word, got_last, got_end);
        return;
      end
      want = expected_pixels.pop_front();
      if (got_word !== want.word || got_last !== want.last_of_run ||
          got_end !== want.line_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
                   $realtime, want.word, want.last_of_run, want.line_end,
                   got_word, got_last, got_end);
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [pcxd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pcxd_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  logic                             op;
  logic [pcxd_pkg::PAL_ADDR_W-1:0]  palette_index;
  logic [pcxd_pkg::PAL_WORD_W-1:0]  palette_value;
  logic [pcxd_pkg::BYTE_W-1:0]      data_byte;
  logic                             out_valid;
  logic                             out_ready;
  logic [pcxd_pkg::PIXEL_WIDTH-1:0] pixel;
  logic                             last_of_run;
  logic                             line_end;

  pcx_pixel_predictor predictor = new();
  bit                 idling_on = 1'b1;

  pcx_rle_line_decoder_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .palette_index(palette_index),
    .palette_value(palette_value),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel(pixel),
    .last_of_run(last_of_run),
    .line_end(line_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** pcx_rle_line_decoder_top: FAILED **");
    $finish;
  end

  // Output side: check every accepted beat, stall in random bursts while idling_on is set.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        predictor.check_pixel(pixel, last_of_run, line_end);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic o, input logic [pcxd_pkg::PAL_ADDR_W-1:0] idx,
                           input logic [pcxd_pkg::PAL_WORD_W-1:0] val,
                           input logic [pcxd_pkg::BYTE_W-1:0] b);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= o;
    palette_index <= idx;
    palette_value <= val;
    data_byte     <= b;
    do @(posedge clk); while (!in_ready);
    predictor.take_byte(o, idx, val, b);
  endtask

  task automatic send_data(input logic [pcxd_pkg::BYTE_W-1:0] b);
    send_item(pcxd_pkg::OP_DATA, pcxd_pkg::PAL_ADDR_W'($urandom),
              pcxd_pkg::PAL_WORD_W'($urandom), b);
  endtask

  task automatic send_palette(input logic [pcxd_pkg::PAL_ADDR_W-1:0] idx,
                              input logic [pcxd_pkg::PAL_WORD_W-1:0] val);
    send_item(pcxd_pkg::OP_PAL_WRITE, idx, val, pcxd_pkg::BYTE_W'($urandom));
  endtask

  // Hold input until every owed pixel is out, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predictor.expected_pixels.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [pcxd_pkg::LINE_W-1:0] len, input logic mode);
    logic [pcxd_pkg::CFG_DATA_W-1:0] mode_word;
    wait_drained();
    mode_word = {(pcxd_pkg::CFG_DATA_W-1)'($urandom), mode};
    cfg_valid <= 1'b1;
    cfg_index <= pcxd_pkg::REG_LINE_LENGTH;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    predictor.write_reg(pcxd_pkg::REG_LINE_LENGTH, len);
    cfg_index <= pcxd_pkg::REG_PALETTE_MODE;
    cfg_data  <= mode_word;
    do @(posedge clk); while (!cfg_ready);
    predictor.write_reg(pcxd_pkg::REG_PALETTE_MODE, mode_word);
    cfg_valid <= 1'b0;
  endtask

  // In palette mode only loaded entries may be selected.
  function automatic logic [pcxd_pkg::BYTE_W-1:0] pick_byte(input int unsigned hi);
    logic [pcxd_pkg::BYTE_W-1:0] b;
    b = pcxd_pkg::BYTE_W'($urandom_range(0, hi));
    while (predictor.palette_mode && !predictor.written[b])
      b = pcxd_pkg::BYTE_W'($urandom_range(0, hi));
    return b;
  endfunction

  task automatic run_random(input int count);
    int unsigned pick;
    int unsigned r;
    logic [pcxd_pkg::BYTE_W-1:0] code;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_palette(pcxd_pkg::PAL_ADDR_W'($urandom), pcxd_pkg::PAL_WORD_W'($urandom));
      end else if (predictor.awaiting_value) begin
        send_data(pick_byte(8'hff));
      end else if (!predictor.palette_mode && pick < 20) begin
        send_data(pcxd_pkg::BYTE_W'($urandom));
      end else if (pick < 55) begin
        r = $urandom_range(0, 19);
        if (r < 2)
          code = pcxd_pkg::RUN_CODE_MIN;
        else if (r < 5)
          code = pcxd_pkg::RUN_CODE_MIN | pcxd_pkg::BYTE_W'($urandom_range(32, 63));
        else
          code = pcxd_pkg::RUN_CODE_MIN | pcxd_pkg::BYTE_W'($urandom_range(1, 8));
        send_data(code);
      end else begin
        send_data(pick_byte(8'hbf));
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    op            <= pcxd_pkg::OP_DATA;
    palette_index <= '0;
    palette_value <= '0;
    data_byte     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: load palette extremes, literals and a run of a code-like value
    send_palette(8'h00, 16'h0000);
    send_palette(8'hff, 16'hffff);
    send_palette(8'hbf, 16'ha5a5);
    send_palette(8'hc0, 16'h5a5a);
    send_palette(8'h7f, 16'h8001);
    send_data(8'h00);
    send_data(pcxd_pkg::RUN_CODE_MIN | 8'h02);
    send_data(8'hff);

    // short lines: palette write inside a run, overshoot, zero count, dangling code
    apply_settings(16'd5, 1'b0);
    send_data(8'h3f);
    send_data(pcxd_pkg::RUN_CODE_MIN | 8'h03);
    send_palette(8'h80, 16'h00ff);
    send_data(8'hc0);
    send_data(pcxd_pkg::RUN_CODE_MIN | pcxd_pkg::RUN_COUNT_MASK);
    send_data(8'h55);
    send_data(pcxd_pkg::RUN_CODE_MIN);
    send_data(8'h12);
    send_data(pcxd_pkg::RUN_CODE_MIN | 8'h05);

    // the line length write drops the pending code
    apply_settings(16'd7, 1'b1);
    send_data(8'h00);
    send_data(8'hbf);
    send_data(pcxd_pkg::RUN_CODE_MIN | 8'h02);
    send_data(8'hff);
    send_data(pcxd_pkg::RUN_CODE_MIN | 8'h09);
    send_data(8'hc0);
    run_random(15);

    apply_settings(16'd1, 1'b0);
    run_random(25);
    apply_settings(16'hffff, 1'b1);
    run_random(25);
    apply_settings(16'd0, 1'b1);
    run_random(25);
    apply_settings(16'd13, 1'b0);
    run_random(25);
    apply_settings(pcxd_pkg::LINE_LENGTH_RESET, 1'b1);
    run_random(20);
    apply_settings(16'd64, 1'b0);
    idling_on = 1'b0;
    run_random(25);

    wait_drained();
    if (predictor.mismatches == 0) begin
      $display("** pcx_rle_line_decoder_top: PASSED **");
    end else begin
      $display("** pcx_rle_line_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
